[rtl/ioleng_pkg.sv]
// Package for the indexed ordered list engine.
// Holds the request kinds, status codes and sequencer states. No dependencies.
package ioleng_pkg;

	// request kinds; codes above KIND_WRITE are unused and leave the list unchanged, but still get a reply
	typedef enum logic [3:0] {
		KIND_PUSH_FRONT = 4'd0,
		KIND_PUSH_BACK  = 4'd1,
		KIND_INSERT     = 4'd2,
		KIND_POP_FRONT  = 4'd3,
		KIND_POP_BACK   = 4'd4,
		KIND_REMOVE     = 4'd5,
		KIND_READ       = 4'd6,
		KIND_CLEAR      = 4'd7,
		KIND_WRITE      = 4'd8
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_CLOSE,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

[rtl/indexed_ordered_list_engine_unit.sv]
// Status-only, write and clear transactions go from accept through ST_DONE to out_valid;
// read passes ST_READ first; pop and remove shift later entries down in ST_CLOSE; push
// and insert shift up in ST_OPEN, none when appending at the end. One entry moves per cycle.
// Throughput: one transaction at a time; in_stall is high until the result is registered.
// Reset: arst_n clears the element count, the sequencer and out_valid; memory contents
// stay undefined until written.
// Top level of the indexed ordered list engine: packed list memory and shift sequencer.
// Depends on ioleng_pkg.
module indexed_ordered_list_engine_unit
	import ioleng_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] word_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] word_out,
	output logic [1:0]  status,
	output logic [4:0]  count,
	output logic        is_empty
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (IDX_W > 5) ? IDX_W : 5;

	// list storage, element i at address i
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	// sequencer and transaction state
	state_t                state_q, state_d;
	logic [IDX_W-1:0]      count_q, count_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [IDX_W-1:0]      pos_q, pos_d;
	logic [DATA_WIDTH-1:0] word_q, word_d;
	logic                  pend_q, pend_d;
	logic                  pend_cap_q, pend_cap_d;
	logic [AW-1:0]         pend_addr_q, pend_addr_d;
	logic [DATA_WIDTH-1:0] res_word_q, res_word_d;
	status_t               res_status_q, res_status_d;

	// output register
	logic                  out_valid_q, out_valid_d;
	logic [31:0]           word_out_q, word_out_d;
	status_t               status_q, status_d;
	logic [4:0]            count_out_q, count_out_d;
	logic                  is_empty_q, is_empty_d;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	logic [IDX_W-1:0]      idx_m1;
	logic [IDX_W-1:0]      cnt_m1;
	logic [DATA_WIDTH-1:0] word_in_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q == IDX_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_c     = CMP_W'(position);
	assign cnt_c     = CMP_W'(count_q);
	assign idx_m1    = idx_q - 1'b1;
	assign cnt_m1    = count_q - 1'b1;
	assign word_in_d = DATA_WIDTH'(word_in);

	assign out_valid = out_valid_q;
	assign word_out  = word_out_q;
	assign status    = status_q;
	assign count     = count_out_q;
	assign is_empty  = is_empty_q;

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// next state, memory control and result capture
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		word_d       = word_q;
		pend_d       = pend_q;
		pend_cap_d   = pend_cap_q;
		pend_addr_d  = pend_addr_q;
		res_word_d   = res_word_q;
		res_status_d = res_status_q;
		mem_re       = 1'b0;
		mem_raddr    = idx_q[AW-1:0];
		mem_we       = 1'b0;
		mem_waddr    = pend_addr_q;
		mem_wdata    = rd_data_q;
		out_valid_d  = out_valid_q && out_stall;
		word_out_d   = word_out_q;
		status_d     = status_q;
		count_out_d  = count_out_q;
		is_empty_d   = is_empty_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_word_d   = '0;
					res_status_d = STATUS_OK;
					pend_d       = 1'b0;
					word_d       = word_in_d;
					state_d      = ST_DONE;
					case (kind_t'(kind))
						KIND_PUSH_FRONT: begin
							if (full) begin
								res_status_d = STATUS_FULL;
							end else begin
								idx_d   = count_q;
								pos_d   = '0;
								state_d = ST_OPEN;
							end
						end
						KIND_PUSH_BACK: begin
							if (full) begin
								res_status_d = STATUS_FULL;
							end else begin
								idx_d   = count_q;
								pos_d   = count_q;
								state_d = ST_OPEN;
							end
						end
						KIND_INSERT: begin
							if (full) begin
								res_status_d = STATUS_FULL;
							end else if (pos_c > cnt_c) begin
								res_status_d = STATUS_RANGE;
							end else begin
								idx_d   = count_q;
								pos_d   = IDX_W'(position);
								state_d = ST_OPEN;
							end
						end
						KIND_POP_FRONT: begin
							if (empty) begin
								res_status_d = STATUS_RANGE;
							end else begin
								idx_d   = '0;
								pos_d   = '0;
								state_d = ST_CLOSE;
							end
						end
						KIND_POP_BACK: begin
							if (empty) begin
								res_status_d = STATUS_RANGE;
							end else begin
								idx_d   = cnt_m1;
								pos_d   = cnt_m1;
								state_d = ST_CLOSE;
							end
						end
						KIND_REMOVE: begin
							if (pos_c >= cnt_c) begin
								res_status_d = STATUS_RANGE;
							end else begin
								idx_d   = IDX_W'(position);
								pos_d   = IDX_W'(position);
								state_d = ST_CLOSE;
							end
						end
						KIND_READ: begin
							if (pos_c >= cnt_c) begin
								res_status_d = STATUS_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(position);
								state_d   = ST_READ;
							end
						end
						KIND_CLEAR: begin
							count_d = '0;
						end
						KIND_WRITE: begin
							if (pos_c >= cnt_c) begin
								res_status_d = STATUS_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(position);
								mem_wdata = word_in_d;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// shift entries up one place, top down, then drop the new word into the gap
			ST_OPEN: begin
				if (pend_q) begin
					mem_we = 1'b1;
					pend_d = 1'b0;
				end
				if (idx_q > pos_q) begin
					mem_re      = 1'b1;
					mem_raddr   = idx_m1[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = idx_q[AW-1:0];
					idx_d       = idx_m1;
				end else if (!pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = word_q;
					count_d   = count_q + 1'b1;
					state_d   = ST_DONE;
				end
			end

			// capture the removed word, then shift entries down one place
			ST_CLOSE: begin
				if (pend_q) begin
					pend_d = 1'b0;
					if (pend_cap_q) begin
						res_word_d = rd_data_q;
					end else begin
						mem_we = 1'b1;
					end
				end
				if (idx_q < count_q) begin
					mem_re      = 1'b1;
					mem_raddr   = idx_q[AW-1:0];
					pend_d      = 1'b1;
					pend_cap_d  = (idx_q == pos_q);
					pend_addr_d = idx_m1[AW-1:0];
					idx_d       = idx_q + 1'b1;
				end else if (!pend_q) begin
					count_d = cnt_m1;
					state_d = ST_DONE;
				end
			end

			ST_READ: begin
				res_word_d = rd_data_q;
				state_d    = ST_DONE;
			end

			// hand the result to the output register once it is free
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					word_out_d  = 32'(res_word_q);
					status_d    = res_status_q;
					count_out_d = 5'(count_q);
					is_empty_d  = (count_q == '0);
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		word_q       <= word_d;
		pend_cap_q   <= pend_cap_d;
		pend_addr_q  <= pend_addr_d;
		res_word_q   <= res_word_d;
		res_status_q <= res_status_d;
		word_out_q   <= word_out_d;
		status_q     <= status_d;
		count_out_q  <= count_out_d;
		is_empty_q   <= is_empty_d;
	end

endmodule

[verif/list_engine_checker.sv]
// Checker for the indexed ordered list engine: watches both channels, predicts each reply
// from its own copy of the list and compares field by field. Depends on ioleng_pkg.
module list_engine_checker
	import ioleng_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [4:0]  position,
	input  logic [31:0] word_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] word_out,
	input  logic [1:0]  status,
	input  logic [4:0]  count,
	input  logic        is_empty,
	output int          mismatch_total,
	output int          replies_outstanding
);

	localparam int REPLY_SLOTS = 8;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] word;
		status_t     st;
		logic [4:0]  len;
		logic        empty;
	} list_reply_t;

	logic [31:0] list_words [LIST_DEPTH];
	int          list_len;
	list_reply_t reply_slots [REPLY_SLOTS];
	int          slot_rd;
	int          slot_wr;
	int          slot_fill;
	int          error_tally;

	// carry out one request on the shadow list and return the reply it should give
	function automatic list_reply_t apply_list_op(logic [3:0] op, logic [4:0] pos,
			logic [31:0] w);
		list_reply_t r;
		int          at;
		r.op = op;
		r.word = '0;
		r.st = STATUS_OK;
		at = -1;
		case (op)
			KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					r.st = STATUS_FULL;
				end else if (op == KIND_INSERT && int'(pos) > list_len) begin
					r.st = STATUS_RANGE;
				end else begin
					at = (op == KIND_PUSH_FRONT) ? 0 :
						(op == KIND_PUSH_BACK) ? list_len : int'(pos);
					for (int i = list_len; i > at; i--)
						list_words[i] = list_words[i - 1];
					list_words[at] = w;
					list_len++;
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK, KIND_REMOVE: begin
				if (op == KIND_REMOVE)
					at = (int'(pos) < list_len) ? int'(pos) : -1;
				else if (list_len > 0)
					at = (op == KIND_POP_FRONT) ? 0 : list_len - 1;
				if (at < 0) begin
					r.st = STATUS_RANGE;
				end else begin
					r.word = list_words[at];
					for (int i = at; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			KIND_READ: begin
				if (int'(pos) >= list_len)
					r.st = STATUS_RANGE;
				else
					r.word = list_words[pos];
			end
			KIND_WRITE: begin
				if (int'(pos) >= list_len)
					r.st = STATUS_RANGE;
				else
					list_words[pos] = w;
			end
			KIND_CLEAR: begin
				list_len = 0;
			end
			default: begin
				// spare codes leave the list alone
			end
		endcase
		r.len = 5'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	// compare replies first, then predict the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		list_reply_t exp_r;
		if (!arst_n) begin
			list_len = 0;
			slot_rd = 0;
			slot_wr = 0;
			slot_fill = 0;
			error_tally = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (slot_fill == 0) begin
					error_tally++;
					if (error_tally <= 10)
						$display({"mismatch: reply with no request waiting: ",
							"word %h status %0d count %0d empty %0b"},
							word_out, status, count, is_empty);
				end else begin
					exp_r = reply_slots[slot_rd];
					slot_rd = (slot_rd + 1) % REPLY_SLOTS;
					slot_fill--;
					if (word_out !== exp_r.word || status !== exp_r.st ||
							count !== exp_r.len || is_empty !== exp_r.empty) begin
						error_tally++;
						if (error_tally <= 10)
							$display({"mismatch: kind %0d expected word %h status %0d ",
								"count %0d empty %0b, got word %h status %0d ",
								"count %0d empty %0b"},
								exp_r.op, exp_r.word, exp_r.st, exp_r.len, exp_r.empty,
								word_out, status, count, is_empty);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (slot_fill >= REPLY_SLOTS) begin
					error_tally++;
					if (error_tally <= 10)
						$display("mismatch: too many requests accepted without a reply");
				end else begin
					reply_slots[slot_wr] = apply_list_op(kind, position, word_in);
					slot_wr = (slot_wr + 1) % REPLY_SLOTS;
					slot_fill++;
				end
			end
		end
		mismatch_total = error_tally;
		replies_outstanding = slot_fill;
	end

endmodule

[verif/tb_top.sv]
// Testbench top for the indexed ordered list engine: clock, reset, request stimulus,
// reply back-pressure and the verdict. Depends on ioleng_pkg and list_engine_checker.
module tb_top;
	import ioleng_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam logic [3:0] KIND_SPARE_FIRST = 4'd9;
	localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;
	localparam int RANDOM_PER_PHASE = 362;

	typedef enum {MOOD_GROW, MOOD_SHRINK, MOOD_MIX} mood_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  kind;
	logic [4:0]  position;
	logic [31:0] word_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] word_out;
	logic [1:0]  status;
	logic [4:0]  count;
	logic        is_empty;

	int mismatch_total;
	int replies_outstanding;
	int send_idle_pct;
	int recv_stall_pct;
	int len_hint;

	indexed_ordered_list_engine_unit #(
		.CAPACITY(LIST_DEPTH),
		.DATA_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.position(position),
		.word_in(word_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_out(word_out),
		.status(status),
		.count(count),
		.is_empty(is_empty)
	);

	list_engine_checker #(
		.LIST_DEPTH(LIST_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.position(position),
		.word_in(word_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_out(word_out),
		.status(status),
		.count(count),
		.is_empty(is_empty),
		.mismatch_total(mismatch_total),
		.replies_outstanding(replies_outstanding)
	);

	always #10 clk = ~clk;

	// stall the reply channel at random
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_stall_pct);
	end

	// track the list length from replies to aim positions at the live range
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			len_hint <= int'(count);
	end

	// give up on a hung run
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// hold one request until accepted; called and returns at a falling edge
	task automatic send_request(logic [3:0] op, logic [4:0] pos, logic [31:0] w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = op;
		position = pos;
		word_in = w;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [3:0] pick_kind(mood_t m);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return 4'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_SPARE_LAST)));
		if (roll < 6)
			return KIND_CLEAR;
		if (m == MOOD_GROW && roll < 75)
			return 4'($urandom_range(int'(KIND_PUSH_FRONT), int'(KIND_INSERT)));
		if (m == MOOD_SHRINK && roll < 75)
			return 4'($urandom_range(int'(KIND_POP_FRONT), int'(KIND_REMOVE)));
		return 4'($urandom_range(int'(KIND_PUSH_FRONT), int'(KIND_WRITE)));
	endfunction

	function automatic logic [4:0] pick_position();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return 5'($urandom_range(0, len_hint));
		if (roll < 95)
			return 5'($urandom_range(0, LIST_DEPTH));
		return 5'($urandom_range(0, 31));
	endfunction

	initial begin
		mood_t mood;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_PUSH_FRONT;
		position = '0;
		word_in = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		len_hint = 0;
		mood = MOOD_GROW;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list refusals
		send_request(KIND_POP_FRONT, 5'd0, 32'h0);
		send_request(KIND_POP_BACK, 5'd0, 32'h0);
		send_request(KIND_REMOVE, 5'd0, 32'h0);
		send_request(KIND_READ, 5'd0, 32'h0);
		send_request(KIND_WRITE, 5'd0, 32'hFFFF_FFFF);
		send_request(KIND_INSERT, 5'd1, 32'h0);
		// directed: build a short list, append by insert at the end
		send_request(KIND_INSERT, 5'd0, 32'hFFFF_FFFF);
		send_request(KIND_PUSH_FRONT, 5'd0, 32'h0000_0000);
		send_request(KIND_PUSH_BACK, 5'd0, 32'h8000_0001);
		send_request(KIND_INSERT, 5'd3, 32'h5555_5555);
		send_request(KIND_INSERT, 5'd5, 32'hAAAA_AAAA);
		// directed: access at the ends and just past them
		send_request(KIND_READ, 5'd0, 32'h0);
		send_request(KIND_READ, 5'd3, 32'h0);
		send_request(KIND_READ, 5'd4, 32'h0);
		send_request(KIND_WRITE, 5'd31, 32'h1234_5678);
		send_request(KIND_WRITE, 5'd2, 32'h1234_5678);
		send_request(KIND_READ, 5'd2, 32'h0);
		send_request(KIND_REMOVE, 5'd1, 32'h0);
		send_request(KIND_POP_BACK, 5'd0, 32'h0);
		send_request(KIND_POP_FRONT, 5'd0, 32'h0);
		// directed: spare codes and clear
		send_request(KIND_SPARE_FIRST, 5'd0, 32'hFFFF_FFFF);
		send_request(KIND_SPARE_LAST, 5'd31, 32'h0);
		send_request(KIND_CLEAR, 5'd0, 32'h0);
		send_request(KIND_CLEAR, 5'd0, 32'h0);

		// random: one phase per idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// switch between filling, draining and mixed traffic
				if (n % 32 == 0)
					mood = mood_t'($urandom_range(0, 2));
				send_request(pick_kind(mood), pick_position(), $urandom);
			end
		end
		in_valid = 1'b0;

		// drain outstanding replies, then let the pipeline settle
		while (replies_outstanding != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_total == 0 && replies_outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
